// ===== rtl/core/diwp_pkg.sv =====
package diwp_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned ValueWidth = 64;
    localparam int unsigned DigitWidth = 4;
    localparam int unsigned ProdWidth  = ValueWidth + DigitWidth;
    localparam int unsigned OutWidth   = 72;

    localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CharWidth-1:0] CHAR_PLUS  = 8'h2b;

    localparam logic [ValueWidth-1:0] INT64_POS_TOP = 64'h7fff_ffff_ffff_ffff;
    localparam logic [ValueWidth-1:0] INT64_NEG_TOP = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        CLASS_INT8,
        CLASS_INT16,
        CLASS_INT32,
        CLASS_INT64
    } t_width_class;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_OVERFLOW,
        STATUS_BAD_CHAR
    } t_parse_status;

    typedef struct packed {
        logic [ValueWidth-1:0] int_value;
        t_width_class          width_class;
        t_parse_status         parse_status;
    } t_result;

    // Largest magnitude that still fits the given class for the given sign.
    function automatic logic [ValueWidth-1:0] class_limit(input logic minus,
                                                          input t_width_class cls);
        logic [ValueWidth-1:0] lim;
        case (cls)
            CLASS_INT8:  lim = minus ? 64'd128        : 64'd127;
            CLASS_INT16: lim = minus ? 64'd32768      : 64'd32767;
            CLASS_INT32: lim = minus ? 64'd2147483648 : 64'd2147483647;
            default:     lim = minus ? INT64_NEG_TOP  : INT64_POS_TOP;
        endcase
        return lim;
    endfunction

endpackage

// ===== rtl/core/decimal_integer_width_parser_unit.sv =====
// Decimal integer parser: turns a stream of ASCII characters into a signed
// 64-bit value together with the narrowest signed width class that holds it.
// The slave channel carries one character per beat in tdata, and tlast marks
// the final character of a number. The master channel carries one beat per
// number: the value, the width class (int8, int16, int32, int64) and a status
// (ok, beyond the int64 range, or a bad character seen, which takes priority).
// A character is taken into an input register and worked on by the accumulator,
// and the result of a final character is loaded into the output register, from
// which it is offered on the master channel.
// One character is accepted every cycle unless a final one waits; the rate is
// set by the multiply-by-ten and limit compare in the accumulator.
// When the receiver stalls, the output register holds its beat; characters
// that are not final still flow on, and a final character waits in the input
// register until the output register is free, which then holds tready low.
// Reset clears the accumulator, the sign, the class and both sticky flags,
// and empties both registers; the state is cleared again after every number.
module decimal_integer_width_parser_unit
    import diwp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [CharWidth-1:0] i_s_tdata,  // [7:0] text_char
    input  logic                 i_s_tlast,  // is_last
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OutWidth-1:0]  o_m_tdata   // [63:0] int_value, [65:64] width_class,
                                             // [67:66] parse_status
);

    logic                 r_in_valid;
    logic [CharWidth-1:0] r_in_char;
    logic                 r_in_last;

    logic    out_busy;
    logic    step;
    t_result result;

    assign step       = r_in_valid && !(r_in_last && out_busy);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    diwp_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (result)
    );

    diwp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step && r_in_last),
        .i_result   (result),
        .o_busy     (out_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== rtl/core/diwp_accum.sv =====
module diwp_accum
    import diwp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [CharWidth-1:0] i_char,
    input  logic                 i_last,
    output t_result              o_result
);

    logic [ValueWidth-1:0] r_mag;
    logic                  r_minus;
    t_width_class          r_class;
    logic                  r_ovf;
    logic                  r_bad;

    logic [ValueWidth-1:0] n_mag;
    logic                  n_minus;
    t_width_class          n_class;
    logic                  n_ovf;
    logic                  n_bad;

    logic                  is_digit;
    logic [DigitWidth-1:0] digit;
    logic [ProdWidth-1:0]  prod;
    logic [ValueWidth-1:0] top;

    always_comb begin
        is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
        digit    = DigitWidth'(i_char - CHAR_ZERO);
        prod     = ({{DigitWidth{1'b0}}, r_mag} << 3) + ({{DigitWidth{1'b0}}, r_mag} << 1)
                 + {{ValueWidth{1'b0}}, digit};
        top      = r_minus ? INT64_NEG_TOP : INT64_POS_TOP;

        n_mag   = r_mag;
        n_minus = r_minus;
        n_class = r_class;
        n_ovf   = r_ovf;
        n_bad   = r_bad;

        if (i_char == CHAR_MINUS) begin
            n_minus = 1'b1;
        end else if (i_char == CHAR_PLUS) begin
            n_minus = r_minus;
        end else if (is_digit) begin
            if (!r_ovf) begin
                if (r_class != CLASS_INT64) begin
                    n_mag = prod[ValueWidth-1:0];
                    if (n_mag > class_limit(r_minus, r_class)) begin
                        n_class = t_width_class'(r_class + 2'd1);
                    end
                end else if (prod > {{DigitWidth{1'b0}}, top}) begin
                    n_ovf = 1'b1;
                end else begin
                    n_mag = prod[ValueWidth-1:0];
                end
            end
        end else begin
            n_bad = 1'b1;
        end

        if (n_bad) begin
            o_result.int_value    = '0;
            o_result.width_class  = CLASS_INT8;
            o_result.parse_status = STATUS_BAD_CHAR;
        end else if (n_ovf) begin
            o_result.int_value    = '0;
            o_result.width_class  = CLASS_INT8;
            o_result.parse_status = STATUS_OVERFLOW;
        end else begin
            o_result.int_value    = n_minus ? (~n_mag + 64'd1) : n_mag;
            o_result.width_class  = n_class;
            o_result.parse_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_minus <= 1'b0;
            r_class <= CLASS_INT8;
            r_ovf   <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_mag   <= '0;
                r_minus <= 1'b0;
                r_class <= CLASS_INT8;
                r_ovf   <= 1'b0;
                r_bad   <= 1'b0;
            end else begin
                r_mag   <= n_mag;
                r_minus <= n_minus;
                r_class <= n_class;
                r_ovf   <= n_ovf;
                r_bad   <= n_bad;
            end
        end
    end

endmodule

// ===== rtl/core/diwp_out_stage.sv =====
module diwp_out_stage
    import diwp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_result             i_result,
    output logic                o_busy,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutWidth-1:0] o_m_tdata
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_busy     = r_valid && !i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(OutWidth - $bits(t_result)){1'b0}},
                         r_result.parse_status, r_result.width_class, r_result.int_value};

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import diwp_pkg::*;

    typedef logic [CharWidth-1:0] t_chars[$];

    localparam int unsigned TotalChars = 1350;
    localparam int unsigned CycleLimit = 300000;

    class parse_scoreboard;
        logic [ValueWidth-1:0] magnitude;
        logic                  minus_seen;
        logic                  overflow_seen;
        logic                  bad_char_seen;
        t_width_class          current_class;
        t_result               expected_results[$];
        int unsigned           errors;
        int unsigned           numbers;
        int unsigned           overflows;
        int unsigned           bad_numbers;
        int unsigned           checked;

        function new();
            errors      = 0;
            numbers     = 0;
            overflows   = 0;
            bad_numbers = 0;
            checked     = 0;
            clear_number();
        endfunction

        function void clear_number();
            magnitude     = '0;
            minus_seen    = 1'b0;
            overflow_seen = 1'b0;
            bad_char_seen = 1'b0;
            current_class = CLASS_INT8;
        endfunction

        function void note_char(logic [CharWidth-1:0] ch, logic last);
            logic [ValueWidth-1:0] digit;
            logic [ValueWidth-1:0] lim;
            logic [ValueWidth-1:0] top;
            t_result               res;
            if (ch == CHAR_MINUS) begin
                minus_seen = 1'b1;
            end else if (ch == CHAR_PLUS) begin
            end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                digit = ValueWidth'(ch - CHAR_ZERO);
                if (!overflow_seen) begin
                    if (current_class != CLASS_INT64) begin
                        magnitude = magnitude * 10 + digit;
                        case (current_class)
                            CLASS_INT8: begin
                                lim = minus_seen ? 64'd128 : 64'd127;
                            end
                            CLASS_INT16: begin
                                lim = minus_seen ? 64'd32768 : 64'd32767;
                            end
                            default: begin
                                lim = minus_seen ? 64'd2147483648 : 64'd2147483647;
                            end
                        endcase
                        if (magnitude > lim) begin
                            current_class = t_width_class'(current_class + 1);
                        end
                    end else begin
                        top = minus_seen ? INT64_NEG_TOP : INT64_POS_TOP;
                        if (magnitude > (top - digit) / 10) begin
                            overflow_seen = 1'b1;
                        end else begin
                            magnitude = magnitude * 10 + digit;
                        end
                    end
                end
            end else begin
                bad_char_seen = 1'b1;
            end
            if (last) begin
                res.int_value    = '0;
                res.width_class  = CLASS_INT8;
                res.parse_status = STATUS_OK;
                if (bad_char_seen) begin
                    res.parse_status = STATUS_BAD_CHAR;
                    bad_numbers++;
                end else if (overflow_seen) begin
                    res.parse_status = STATUS_OVERFLOW;
                    overflows++;
                end else begin
                    res.int_value   = minus_seen ? -magnitude : magnitude;
                    res.width_class = current_class;
                end
                expected_results.push_back(res);
                numbers++;
                clear_number();
            end
        endfunction

        function void check_beat(logic [OutWidth-1:0] beat);
            t_result got;
            t_result want;
            got.int_value    = beat[ValueWidth-1:0];
            got.width_class  = t_width_class'(beat[ValueWidth+1:ValueWidth]);
            got.parse_status = t_parse_status'(beat[ValueWidth+3:ValueWidth+2]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected beat, value %0d class %0d status %0d", $time,
                         $signed(got.int_value), got.width_class, got.parse_status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.int_value !== want.int_value) begin
                $display("%0t: int_value expected %0d got %0d", $time,
                         $signed(want.int_value), $signed(got.int_value));
                errors++;
            end
            if (got.width_class !== want.width_class) begin
                $display("%0t: width_class expected %0d got %0d", $time,
                         want.width_class, got.width_class);
                errors++;
            end
            if (got.parse_status !== want.parse_status) begin
                $display("%0t: parse_status expected %0d got %0d", $time,
                         want.parse_status, got.parse_status);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CharWidth-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutWidth-1:0]  m_tdata;

    int unsigned     idle_pct = 0;
    int unsigned     stall_pct = 0;
    int unsigned     chars_sent = 0;
    int unsigned     cycle_count = 0;
    parse_scoreboard sb = new();

    string bounds[8] = '{"127", "128", "32767", "32768", "2147483647", "2147483648",
                         "9223372036854775807", "9223372036854775808"};
    string directed_texts[8] = '{"-", "+", "9", "12-8", "128", "9a",
                                 "-9223372036854775808", "9223372036854775808"};

    decimal_integer_width_parser_unit u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_beat(m_tdata);
        end
    end

    function automatic t_chars to_chars(string s);
        t_chars q;
        q = {};
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    task automatic send_char(input logic [CharWidth-1:0] ch, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_char(ch, last);
        chars_sent++;
    endtask

    task automatic send_text(input t_chars text);
        for (int i = 0; i < text.size(); i++) begin
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    initial begin
        t_chars      text;
        int unsigned kind;
        int unsigned len;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        text = {8'h00};
        send_text(text);
        text = {8'hff};
        send_text(text);
        foreach (directed_texts[i]) begin
            send_text(to_chars(directed_texts[i]));
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 72;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 72;
                end
                default: begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            while (chars_sent < (phase + 1) * TotalChars / 4) begin
                kind = $urandom_range(0, 99);
                text = {};
                if (kind < 50) begin
                    len = $urandom_range(1, 20);
                    repeat (len) text.push_back(CharWidth'(CHAR_ZERO + $urandom_range(0, 9)));
                end else if (kind < 70) begin
                    text = to_chars(bounds[$urandom_range(0, 7)]);
                    text[text.size() - 1] =
                        CharWidth'(text[text.size() - 1] + $urandom_range(0, 2) - 1);
                end else if (kind < 80) begin
                    len = $urandom_range(1, 19);
                    repeat (len) text.push_back(CharWidth'(CHAR_ZERO + $urandom_range(0, 9)));
                    text.insert($urandom_range(0, text.size()), CHAR_MINUS);
                    if ($urandom_range(0, 1)) begin
                        text.insert($urandom_range(0, text.size()), CHAR_PLUS);
                    end
                end else if (kind < 88) begin
                    len = $urandom_range(20, 26);
                    text.push_back(CharWidth'(CHAR_ZERO + $urandom_range(1, 9)));
                    repeat (len - 1) begin
                        text.push_back(CharWidth'(CHAR_ZERO + $urandom_range(0, 9)));
                    end
                end else begin
                    len = $urandom_range(1, 6);
                    repeat (len) begin
                        if ($urandom_range(0, 1)) begin
                            text.push_back(CharWidth'($urandom_range(0, 255)));
                        end else begin
                            text.push_back(CharWidth'(CHAR_ZERO + $urandom_range(0, 9)));
                        end
                    end
                end
                if (kind < 90) begin
                    case ($urandom_range(0, 3))
                        0: text.push_front(CHAR_MINUS);
                        1: text.push_front(CHAR_PLUS);
                        default: begin
                        end
                    endcase
                end
                send_text(text);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d characters in %0d numbers over four handshake phases.",
                 chars_sent, sb.numbers);
        $display("Checked %0d beats: %0d beyond int64, %0d with bad characters.",
                 sb.checked, sb.overflows, sb.bad_numbers);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
